// ===== rtl/v3a_pkg.sv =====
// v3a_pkg: opcodes and pipeline control types for the vector ALU.
// No dependencies; imported by v3a_lane, vector3_alu and the testbench.
package v3a_pkg;

  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_SUB   = 3'd2;
  localparam logic [2:0] OP_MUL   = 3'd3;
  localparam logic [2:0] OP_CROSS = 3'd4;
  localparam logic [2:0] OP_MAG   = 3'd5;

  typedef struct packed {
    logic       valid;
    logic [2:0] op;
  } v3a_ctl_t;

endpackage

// ===== rtl/v3a_lane.sv =====
// v3a_lane: one component lane, two multipliers and an adder, two stages.
// Depends on v3a_pkg for the opcodes.
module v3a_lane import v3a_pkg::*; #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic [2:0]          op,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic signed [W-1:0] a_n1,
  input  logic signed [W-1:0] b_n1,
  input  logic signed [W-1:0] a_n2,
  input  logic signed [W-1:0] b_n2,
  output logic signed [2*W:0] res,
  output logic [2*W-1:0]      sq_a,
  output logic [2*W-1:0]      sq_b
);

  localparam int PW = 2 * W;

  logic [2:0]           op_s1;
  logic signed [W-1:0]  m0a, m0b, m1a, m1b;
  logic signed [PW-1:0] p0, p1;
  logic signed [W:0]    sum;

  always_comb begin
    case (op)
      OP_CROSS: begin
        m0a = a_n1; m0b = b_n2;
        m1a = a_n2; m1b = b_n1;
      end
      OP_MAG: begin
        m0a = a; m0b = a;
        m1a = b; m1b = b;
      end
      default: begin
        m0a = a;  m0b = b;
        m1a = '0; m1b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_s1 <= op;
    p0    <= m0a * m0b;
    p1    <= m1a * m1b;
    if (op == OP_SUB) begin
      sum <= {a[W-1], a} - {b[W-1], b};
    end else begin
      sum <= {a[W-1], a} + {b[W-1], b};
    end
  end

  always_ff @(posedge clk) begin
    case (op_s1)
      OP_ADD, OP_SUB: res <= {{W{sum[W]}}, sum};
      OP_MUL:         res <= {p0[PW-1], p0};
      OP_CROSS:       res <= {p0[PW-1], p0} - {p1[PW-1], p1};
      default:        res <= '0;
    endcase
    sq_a <= $unsigned(p0);
    sq_b <= $unsigned(p1);
  end

endmodule

// ===== rtl/v3a_sqrt.sv =====
// v3a_sqrt: pipelined floor square root, one root bit per stage, W stages.
// No package dependencies.
module v3a_sqrt #(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic [2*W-1:0] n,
  output logic [W-1:0]   root
);

  logic [W+1:0]   rem_q  [W+1];
  logic [W-1:0]   root_q [W+1];
  logic [2*W-1:0] n_q    [W+1];

  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign n_q[0]    = n;

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W+1:0] rem_s;
    logic [W+1:0] trial;

    assign rem_s = {rem_q[i][W-1:0], n_q[i][2*W-1:2*W-2]};
    assign trial = {root_q[i], 2'b01};

    always_ff @(posedge clk) begin
      n_q[i+1] <= {n_q[i][2*W-3:0], 2'b00};
      if (rem_s >= trial) begin
        rem_q[i+1]  <= rem_s - trial;
        root_q[i+1] <= {root_q[i][W-2:0], 1'b1};
      end else begin
        rem_q[i+1]  <= rem_s;
        root_q[i+1] <= {root_q[i][W-2:0], 1'b0};
      end
    end
  end

  assign root = root_q[W];

endmodule

// ===== rtl/vector3_alu.sv =====
// vector3_alu: three-component integer vector ALU, top level.
// Depends on v3a_pkg, v3a_lane and v3a_sqrt.
//
// Usage:
//   An item (opcode and two vectors a, b) is taken at a rising edge with
//   start high and busy low. busy is held low: the block takes one beat
//   every cycle, with any number of items in flight.
//   Each item gives one result beat: done is high for one cycle with
//   res_x/res_y/res_z, len_a/len_b and status on the ports.
//   Three lanes, one per component, do the multiplies and adds in two
//   stages, a merge stage sums the squares, and a square root pipeline
//   of one stage per root bit sets the rest; every opcode goes down the
//   same pipe, so results leave in order.
//   Throughput: one item per cycle.
//   Reset (rst, synchronous) drops every item in flight; no result
//   follows it. The receiver cannot stall: results are never held.
module vector3_alu import v3a_pkg::*; #(
  parameter int COMP_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   opcode,
  input  logic signed [COMP_WIDTH-1:0] a_x,
  input  logic signed [COMP_WIDTH-1:0] a_y,
  input  logic signed [COMP_WIDTH-1:0] a_z,
  input  logic signed [COMP_WIDTH-1:0] b_x,
  input  logic signed [COMP_WIDTH-1:0] b_y,
  input  logic signed [COMP_WIDTH-1:0] b_z,
  output logic                         done,
  output logic signed [31:0]           res_x,
  output logic signed [31:0]           res_y,
  output logic signed [31:0]           res_z,
  output logic [15:0]                  len_a,
  output logic [15:0]                  len_b,
  output logic                         status
);

  localparam int W     = COMP_WIDTH;
  localparam int PW    = 2 * W;
  localparam int DEPTH = W + 3;

  logic signed [W-1:0]  comp_a [3];
  logic signed [W-1:0]  comp_b [3];
  logic signed [PW:0]   lane_res [3];
  logic [PW-1:0]        lane_sqa [3];
  logic [PW-1:0]        lane_sqb [3];

  v3a_ctl_t             ctl [DEPTH];
  logic signed [PW:0]   res_s3 [3];
  logic signed [PW:0]   res_dly [W][3];
  logic [PW-1:0]        sq_sum_a, sq_sum_b;
  logic [W-1:0]         root_a, root_b;

  logic [63:0]          res_ext [3];
  logic [63:0]          len_a_ext, len_b_ext;
  logic                 is_mag;
  logic                 bad_op;

  assign busy = 1'b0;

  assign comp_a = '{a_x, a_y, a_z};
  assign comp_b = '{b_x, b_y, b_z};

  for (genvar l = 0; l < 3; l++) begin : g_lane
    v3a_lane #(.W(W)) u_lane (
      .clk  (clk),
      .op   (opcode),
      .a    (comp_a[l]),
      .b    (comp_b[l]),
      .a_n1 (comp_a[(l + 1) % 3]),
      .b_n1 (comp_b[(l + 1) % 3]),
      .a_n2 (comp_a[(l + 2) % 3]),
      .b_n2 (comp_b[(l + 2) % 3]),
      .res  (lane_res[l]),
      .sq_a (lane_sqa[l]),
      .sq_b (lane_sqb[l])
    );
  end

  // control pipe, aligned with the data stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        ctl[k] <= '0;
      end
    end else begin
      ctl[0] <= '{valid: start, op: opcode};
      for (int k = 1; k < DEPTH; k++) begin
        ctl[k] <= ctl[k-1];
      end
    end
  end

  // merge stage
  always_ff @(posedge clk) begin
    sq_sum_a <= lane_sqa[0] + lane_sqa[1] + lane_sqa[2];
    sq_sum_b <= lane_sqb[0] + lane_sqb[1] + lane_sqb[2];
    res_s3   <= lane_res;
  end

  v3a_sqrt #(.W(W)) u_sqrt_a (
    .clk  (clk),
    .n    (sq_sum_a),
    .root (root_a)
  );

  v3a_sqrt #(.W(W)) u_sqrt_b (
    .clk  (clk),
    .n    (sq_sum_b),
    .root (root_b)
  );

  always_ff @(posedge clk) begin
    res_dly[0] <= res_s3;
    for (int k = 1; k < W; k++) begin
      res_dly[k] <= res_dly[k-1];
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      res_ext[l] = {{(63 - PW){res_dly[W-1][l][PW]}}, res_dly[W-1][l]};
    end
    len_a_ext = {{(64 - W){1'b0}}, root_a};
    len_b_ext = {{(64 - W){1'b0}}, root_b};
    is_mag    = (ctl[DEPTH-1].op == OP_MAG);
    bad_op    = !(ctl[DEPTH-1].op inside {[OP_ADD:OP_MAG]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl[DEPTH-1].valid;
    end
    res_x  <= res_ext[0][31:0];
    res_y  <= res_ext[1][31:0];
    res_z  <= res_ext[2][31:0];
    len_a  <= is_mag ? len_a_ext[15:0] : 16'd0;
    len_b  <= is_mag ? len_b_ext[15:0] : 16'd0;
    status <= bad_op;
  end

endmodule

// ===== tb/tb_vector3_alu.sv =====
// tb_vector3_alu: self-checking testbench for the vector3_alu block.
// Depends on v3a_pkg and vector3_alu; a queue-fed driver, a predicting monitor,
// and directed plus random beats with random gaps between them.
module tb_vector3_alu import v3a_pkg::*;;

  localparam int          COMP_WIDTH  = 16;
  localparam int          NUM_RANDOM  = 1450;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          DRAIN_CYCLES = 48;
  localparam int          MAX_REPORTS = 10;
  localparam logic [2:0]  OP_NONE = 3'd0;
  localparam logic [2:0]  OP_RSV6 = 3'd6;
  localparam logic [2:0]  OP_RSV7 = 3'd7;
  localparam logic signed [COMP_WIDTH-1:0] CMAX = 16'sh7fff;
  localparam logic signed [COMP_WIDTH-1:0] CMIN = 16'sh8000;

  typedef struct {
    logic [2:0]                   opcode;
    logic signed [COMP_WIDTH-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
    int                           gap;
  } vec_beat_t;

  typedef struct {
    logic signed [31:0] res_x, res_y, res_z;
    logic [15:0]        len_a, len_b;
    logic               status;
  } vec_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] opcode = '0;
  logic signed [COMP_WIDTH-1:0] a_x = '0, a_y = '0, a_z = '0;
  logic signed [COMP_WIDTH-1:0] b_x = '0, b_y = '0, b_z = '0;
  logic done;
  logic signed [31:0] res_x, res_y, res_z;
  logic [15:0] len_a, len_b;
  logic status;

  vec_beat_t   pending_beats[$];
  vec_result_t expected_results[$];
  vec_beat_t   cur_beat;
  logic        took = 1'b0;
  int          hold_off = 0;
  int          total_beats = 0;
  int          beats_taken = 0;
  int          results_checked = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          op_count[8];

  vector3_alu dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .done(done), .res_x(res_x), .res_y(res_y), .res_z(res_z),
    .len_a(len_a), .len_b(len_b), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] floor_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    return root[15:0];
  endfunction

  function automatic vec_result_t predict_vector_op(vec_beat_t b);
    longint ax, ay, az, bx, by, bz;
    longint rx, ry, rz;
    vec_result_t r;
    ax = b.a_x; ay = b.a_y; az = b.a_z;
    bx = b.b_x; by = b.b_y; bz = b.b_z;
    rx = 0; ry = 0; rz = 0;
    r.len_a = '0;
    r.len_b = '0;
    r.status = 1'b0;
    case (b.opcode)
      OP_ADD: begin
        rx = ax + bx; ry = ay + by; rz = az + bz;
      end
      OP_SUB: begin
        rx = ax - bx; ry = ay - by; rz = az - bz;
      end
      OP_MUL: begin
        rx = ax * bx; ry = ay * by; rz = az * bz;
      end
      OP_CROSS: begin
        rx = ay * bz - az * by;
        ry = az * bx - ax * bz;
        rz = ax * by - ay * bx;
      end
      OP_MAG: begin
        r.len_a = floor_sqrt(ax * ax + ay * ay + az * az);
        r.len_b = floor_sqrt(bx * bx + by * by + bz * bz);
      end
      default: r.status = 1'b1;
    endcase
    r.res_x = rx[31:0];
    r.res_y = ry[31:0];
    r.res_z = rz[31:0];
    return r;
  endfunction

  function automatic logic signed [COMP_WIDTH-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return CMIN;
      1: return CMAX;
      2: return '0;
      3, 4: return COMP_WIDTH'($signed($urandom_range(0, 16)) - 8);
      default: return COMP_WIDTH'($urandom());
    endcase
  endfunction

  // long runs of back-to-back beats alternate with runs of random gaps
  function automatic int draw_gap(int idx);
    if ((idx / 64) % 3 == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  task automatic queue_beat(logic [2:0] op,
                            logic signed [COMP_WIDTH-1:0] ax, ay, az, bx, by, bz);
    vec_beat_t b;
    b.opcode = op;
    b.a_x = ax; b.a_y = ay; b.a_z = az;
    b.b_x = bx; b.b_y = by; b.b_z = bz;
    b.gap = draw_gap(total_beats);
    pending_beats.push_back(b);
    total_beats++;
  endtask

  task automatic note_mismatch(string field, longint want, longint got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0d] %s mismatch: expected %0d, got %0d", cycle_count, field, want, got);
  endtask

  task automatic check_result(vec_result_t want, vec_result_t got);
    if (got.res_x !== want.res_x) note_mismatch("res_x", want.res_x, got.res_x);
    if (got.res_y !== want.res_y) note_mismatch("res_y", want.res_y, got.res_y);
    if (got.res_z !== want.res_z) note_mismatch("res_z", want.res_z, got.res_z);
    if (got.len_a !== want.len_a) note_mismatch("len_a", want.len_a, got.len_a);
    if (got.len_b !== want.len_b) note_mismatch("len_b", want.len_b, got.len_b);
    if (got.status !== want.status) note_mismatch("status", want.status, got.status);
  endtask

  // driver: inputs move on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !took) begin
      start <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off--;
      start <= 1'b0;
      opcode <= 3'($urandom());
      a_x <= rand_comp(); a_y <= rand_comp(); a_z <= rand_comp();
      b_x <= rand_comp(); b_y <= rand_comp(); b_z <= rand_comp();
    end else if (pending_beats.size() != 0) begin
      cur_beat = pending_beats.pop_front();
      hold_off = cur_beat.gap;
      start <= 1'b1;
      opcode <= cur_beat.opcode;
      a_x <= cur_beat.a_x; a_y <= cur_beat.a_y; a_z <= cur_beat.a_z;
      b_x <= cur_beat.b_x; b_y <= cur_beat.b_y; b_z <= cur_beat.b_z;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: sample on the rising edge, check results, then log the new beat
  always @(posedge clk) begin
    vec_beat_t   seen;
    vec_result_t got;
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (done) begin
        got.res_x = res_x; got.res_y = res_y; got.res_z = res_z;
        got.len_a = len_a; got.len_b = len_b; got.status = status;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0d] result beat with nothing outstanding", cycle_count);
        end else begin
          check_result(expected_results.pop_front(), got);
          results_checked++;
        end
      end
      if (start && !busy) begin
        seen.opcode = opcode;
        seen.a_x = a_x; seen.a_y = a_y; seen.a_z = a_z;
        seen.b_x = b_x; seen.b_y = b_y; seen.b_z = b_z;
        seen.gap = 0;
        expected_results.push_back(predict_vector_op(seen));
        op_count[opcode]++;
        beats_taken++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout: %0d beats taken, %0d results outstanding",
               beats_taken, expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [2:0] valid_ops[5];
    logic [2:0] bad_ops[3];
    int         r;
    valid_ops = '{OP_ADD, OP_SUB, OP_MUL, OP_CROSS, OP_MAG};
    bad_ops = '{OP_NONE, OP_RSV6, OP_RSV7};
    foreach (op_count[i]) op_count[i] = 0;

    // directed beats
    queue_beat(OP_ADD, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    queue_beat(OP_ADD, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    queue_beat(OP_ADD, -16'sd1, 16'sd1, 16'sd0, 16'sd1, -16'sd1, 16'sd0);
    queue_beat(OP_SUB, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    queue_beat(OP_SUB, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    queue_beat(OP_MUL, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    queue_beat(OP_MUL, CMIN, CMAX, 16'sd0, CMAX, CMIN, CMIN);
    queue_beat(OP_CROSS, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1);
    queue_beat(OP_CROSS, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd0);
    queue_beat(OP_CROSS, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6, 16'sd7);
    queue_beat(OP_CROSS, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX);
    queue_beat(OP_CROSS, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX);
    queue_beat(OP_MAG, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    queue_beat(OP_MAG, 16'sd3, 16'sd4, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    queue_beat(OP_MAG, -16'sd1, -16'sd2, -16'sd2, 16'sd2, 16'sd3, 16'sd6);
    queue_beat(OP_NONE, CMAX, CMIN, 16'sd5, -16'sd5, CMAX, CMIN);
    queue_beat(OP_RSV6, CMIN, CMAX, -16'sd1, 16'sd1, CMIN, CMAX);
    queue_beat(OP_RSV7, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1);

    // random beats, mostly valid opcodes
    for (int i = 0; i < NUM_RANDOM; i++) begin
      r = $urandom_range(0, 19);
      queue_beat(r < 17 ? valid_ops[r % 5] : bad_ops[r % 3],
                 rand_comp(), rand_comp(), rand_comp(),
                 rand_comp(), rand_comp(), rand_comp());
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (beats_taken < total_beats) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d beats: add %0d, sub %0d, mul %0d, cross %0d, mag %0d, invalid %0d",
             beats_taken, op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL],
             op_count[OP_CROSS], op_count[OP_MAG],
             op_count[OP_NONE] + op_count[OP_RSV6] + op_count[OP_RSV7]);
    $display("%0d results checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
